/* rtl/pll_rate_from_control_word_defines.svh */
// Assertion macros shared by the checker of the PLL rate block.
`ifndef PLL_RATE_FROM_CONTROL_WORD_DEFINES_SVH
`define PLL_RATE_FROM_CONTROL_WORD_DEFINES_SVH
// Plain property check on clk_i, disabled while rst_ni is low.
`define PRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pll rate check failed");
// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define PRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pll rate sequence check failed");
`endif

/* rtl/prc_pkg.sv */
// Package with widths and codes of the PLL rate block.
`timescale 1ns / 1ps
package prc_pkg;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RefW   = 31;
  localparam int unsigned RateW  = 43;
  localparam int unsigned RW     = 32;   // r = 2*ref/(pd+1)
  localparam int unsigned MfiW   = 4;
  localparam int unsigned MagW   = 10;
  localparam int unsigned PdDivW = 5;    // pd+1, up to 16
  localparam int unsigned MfdDivW = 11;  // mfd+1, up to 1024
  localparam int unsigned WholeW = RW + MfiW;
  localparam int unsigned ProdW  = RW + MagW;
  localparam logic [MfiW-1:0] MfiFloor = 4'd5;

  typedef enum logic [1:0] {
    VarUnsignedA = 2'd0,
    VarUnsignedB = 2'd1,
    VarSignMag   = 2'd2,
    VarTwosComp  = 2'd3
  } variant_e;
endpackage

/* rtl/prc_div_cell.sv */
// One restoring division step with a pipeline register and sideband payload.
`timescale 1ns / 1ps
module prc_div_cell #(
  parameter int unsigned N  = 32,
  parameter int unsigned D  = 5,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [N-1:0]  num_i,
  input  logic [D-1:0]  rem_i,
  input  logic [D-1:0]  div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [N-1:0]  num_o,
  output logic [D-1:0]  rem_o,
  output logic [D-1:0]  div_o,
  output logic [SW-1:0] side_o
);
  logic          valid_q;
  logic [N-1:0]  num_q, num_d;
  logic [D-1:0]  rem_q, rem_d, div_q;
  logic [SW-1:0] side_q;
  logic [D:0]    trial;
  logic          fits;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_i, num_i[N-1]};
    fits  = trial >= {1'b0, div_i};
    rem_d = fits ? D'(trial - {1'b0, div_i}) : trial[D-1:0];
    num_d = {num_i[N-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign side_o  = side_q;
endmodule

/* rtl/prc_div_chain.sv */
// Row of N division cells giving an N-bit quotient, one bit per cell.
`timescale 1ns / 1ps
module prc_div_chain #(
  parameter int unsigned N  = 32,
  parameter int unsigned D  = 5,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [N-1:0]  num_i,
  input  logic [D-1:0]  div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [N-1:0]  quot_o,
  output logic [SW-1:0] side_o
);
  logic          vld  [N+1];
  logic [N-1:0]  num  [N+1];
  logic [D-1:0]  rem  [N+1];
  logic [D-1:0]  dv   [N+1];
  logic [SW-1:0] side [N+1];

  assign vld[0]  = valid_i;
  assign num[0]  = num_i;
  assign rem[0]  = '0;
  assign dv[0]   = div_i;
  assign side[0] = side_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    prc_div_cell #(.N(N), .D(D), .SW(SW)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(vld[g]), .num_i(num[g]), .rem_i(rem[g]), .div_i(dv[g]),
      .side_i(side[g]),
      .valid_o(vld[g+1]), .num_o(num[g+1]), .rem_o(rem[g+1]), .div_o(dv[g+1]),
      .side_o(side[g+1])
    );
  end

  assign valid_o = vld[N];
  assign quot_o  = num[N];
  assign side_o  = side[N];
endmodule

/* rtl/pll_rate_from_control_word.sv */
// Top level of the PLL output rate calculator.
//
// Usage: one transaction on the slave stream carries a PLL control word in
// tdata[31:0] and the reference frequency in tdata[62:32]. For each one the
// master stream returns one transaction with the output frequency in
// tdata[42:0] and the underflow flag in tuser.
// The control word holds mfn (9:0), mfi (13:10), mfd (25:16) and pd (29:26).
// The configuration register selects how mfn is read and may only be written
// while no transaction is in flight.
// From input acceptance to output valid, a transaction passes through 32 cells of
// the first divider (one quotient bit each), one multiply stage, 42 cells of
// the second divider and one output register. Throughput is one transaction
// per cycle while s_axis_tready is high, as every cell hands its work to the next one.
// All stages advance together; when the receiver stalls with a result held in
// the output register, the whole row holds and s_axis_tready drops.
// Reset clears all valid bits and sets the variant register to 3 (two's
// complement mfn).
`timescale 1ns / 1ps
module pll_rate_from_control_word
  import prc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // pll_control_word, reference_rate, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // output_rate, zero pad
  output logic        m_axis_tuser    // underflow
);
  localparam int unsigned Side1W = MfiW + MagW + 1 + MfdDivW;
  localparam int unsigned Side2W = WholeW + 1;

  variant_e variant_q;
  logic     en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VarTwosComp;
    end else if (cfg_we_i) begin
      variant_q <= variant_e'(cfg_wdata_i);
    end
  end

  // Decode of the incoming control word.
  logic [WordW-1:0]   word;
  logic [RefW-1:0]    ref_rate;
  logic [9:0]         mfn;
  logic [MfiW-1:0]    mfi;
  logic [MagW-1:0]    mag;
  logic               neg;
  logic [MfdDivW-1:0] mfd_div;
  logic [PdDivW-1:0]  pd_div;

  always_comb begin
    word     = s_axis_tdata[31:0];
    ref_rate = s_axis_tdata[62:32];
    mfn      = word[9:0];
    mfi      = (word[13:10] < MfiFloor) ? MfiFloor : word[13:10];
    mfd_div  = {1'b0, word[25:16]} + 11'd1;
    pd_div   = {1'b0, word[29:26]} + 5'd1;
    neg      = 1'b0;
    mag      = mfn;
    case (variant_q)
      VarSignMag: begin
        neg = mfn[9];
        mag = {1'b0, mfn[8:0]};
      end
      VarTwosComp: begin
        neg = mfn[9];
        mag = mfn[9] ? MagW'(10'd0 - mfn) : mfn;
      end
      default: begin
        neg = 1'b0;
        mag = mfn;
      end
    endcase
  end

  // The whole row advances unless a result waits in the output register.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic              d1_valid;
  logic [RW-1:0]     r_quot;
  logic [Side1W-1:0] d1_side;

  prc_div_chain #(.N(RW), .D(PdDivW), .SW(Side1W)) u_div_ref (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid),
    .num_i({ref_rate, 1'b0}),
    .div_i(pd_div),
    .side_i({mfi, mag, neg, mfd_div}),
    .valid_o(d1_valid), .quot_o(r_quot), .side_o(d1_side)
  );

  // Multiply stage: r*mfi and r*|mfn|.
  logic               mul_valid_q;
  logic [WholeW-1:0]  whole_q;
  logic [ProdW-1:0]   prod_q;
  logic               neg_q;
  logic [MfdDivW-1:0] mfd_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      whole_q   <= WholeW'(r_quot) * WholeW'(d1_side[Side1W-1 -: MfiW]);
      prod_q    <= ProdW'(r_quot) * ProdW'(d1_side[MagW+MfdDivW -: MagW]);
      neg_q     <= d1_side[MfdDivW];
      mfd_div_q <= d1_side[MfdDivW-1:0];
    end
  end

  logic              d2_valid;
  logic [ProdW-1:0]  frac;
  logic [Side2W-1:0] d2_side;

  prc_div_chain #(.N(ProdW), .D(MfdDivW), .SW(Side2W)) u_div_frac (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(mul_valid_q),
    .num_i(prod_q),
    .div_i(mfd_div_q),
    .side_i({whole_q, neg_q}),
    .valid_o(d2_valid), .quot_o(frac), .side_o(d2_side)
  );

  // Final add or subtract into the output register.
  logic [RateW-1:0] whole_ext, frac_ext, rate_d;
  logic             uf_d;
  logic             out_valid_q;
  logic [RateW-1:0] rate_q;
  logic             uf_q;

  always_comb begin
    whole_ext = RateW'(d2_side[Side2W-1:1]);
    frac_ext  = RateW'(frac);
    uf_d      = 1'b0;
    if (d2_side[0]) begin
      if (frac_ext > whole_ext) begin
        rate_d = '0;
        uf_d   = 1'b1;
      end else begin
        rate_d = whole_ext - frac_ext;
      end
    end else begin
      rate_d = whole_ext + frac_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rate_q <= rate_d;
      uf_q   <= uf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, rate_q};
  assign m_axis_tuser  = uf_q;
endmodule

/* rtl/prc_checker.sv */
// Port-level checker of the PLL rate block, bound to the top level.
`timescale 1ns / 1ps
`include "pll_rate_from_control_word_defines.svh"
module prc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `PRC_ASSERT(a_uf_zero, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata[42:0] == 43'd0))
  `PRC_ASSERT(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[47:43] == 5'd0))
  `PRC_ASSERT(a_ready_free, m_axis_tvalid || s_axis_tready)
  `PRC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind pll_rate_from_control_word prc_checker u_prc_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
